[hw/rtl/mqs_pkg.sv]
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared types and constants of the multilevel queue scheduler core.
// ----------------------------------------------------------------------------
package mqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_CLASSES     = 5;
	localparam int NUM_RR          = 3;
	localparam int CLS_W           = 3;
	localparam int RR_IW           = 2;
	localparam int SLICE_W         = 4;
	localparam logic [SLICE_W-1:0] RESET_SLICE = 4'd3;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic {
		REG_TIME_SLICE = 1'b0,
		REG_UNUSED     = 1'b1
	} reg_index_t;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	typedef struct packed {
		logic [0:0]  func;
		logic [2:0]  queue_class;
		logic [15:0] job_id;
		logic [7:0]  exec_time;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        ran_valid;
		logic [15:0] ran_id;
		logic [2:0]  ran_class;
		logic        job_done;
	} result_t;

	typedef struct packed {
		logic [15:0] job_id;
		logic [7:0]  remaining;
	} job_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_READ,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/multilevel_queue_scheduler_core.sv]
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core
// Five-class job scheduler: classes 0-2 round robin with a programmable time
// slice, classes 3-4 first come first served, fixed priority between classes.
// ----------------------------------------------------------------------------
//
//  channel   signals                            direction  moves
//  item      item_valid / item_stall / item     in         add or tick
//  result    result_valid / result_stall / result out      one result per item
//  config    psel penable pwrite paddr pwdata   in/out     time_slice register
//
//  An add or an idle tick passes from the decide state straight to done.
//  A tick that runs a job reads and then writes the job table, and before
//  that runs the slot scan (up to QUEUE_DEPTH slots visited) when the turn moves on,
//  and on every first come first served tick.
//  The scan and the single job-table port make a running tick the slowest item.
//  Reset clears queue counts, turn pointers, slice counters and the pending
//  mask; the job table itself is not cleared and needs no clearing pass.
//  A finished result waits in the output register while the next item is
//  taken; the sequencer holds in its done state only if that register is full.
//
module multilevel_queue_scheduler_core
	import mqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH);

	logic [SLICE_W-1:0] time_slice_q;
	reg_index_t         reg_idx;

	logic      res_valid;
	result_t   res;
	logic      res_taken;
	logic      result_valid_q;
	result_t   result_q;

	logic      mem_we;
	logic      mem_re;
	logic [AW-1:0] mem_addr;
	job_word_t mem_wdata;
	job_word_t mem_rdata;

	// Register file: one 4-bit register at bytes 0-3 (paddr[2] low), bytes 4-7 read zero.
	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[2]);
	assign prdata  = (reg_idx == REG_TIME_SLICE) ? APB_DW'(time_slice_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= RESET_SLICE;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_TIME_SLICE) begin
			time_slice_q <= pwdata[SLICE_W-1:0];
		end
	end

	// Output register: load when empty or when its transfer completes now.
	assign res_taken = res_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_taken) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	mqs_sched_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.time_slice (time_slice_q),
		.res_valid  (res_valid),
		.res        (res),
		.res_taken  (res_taken),
		.mem_we     (mem_we),
		.mem_re     (mem_re),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata)
	);

	mqs_job_mem #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_job_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

[hw/rtl/mqs_job_mem.sv]
// ----------------------------------------------------------------------------
// mqs_job_mem
// Job table: id and remaining time of every slot, one port, registered read.
// ----------------------------------------------------------------------------
module mqs_job_mem
	import mqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
	input  logic      clk,
	input  logic      we,
	input  logic      re,
	input  logic [AW-1:0] addr,
	input  job_word_t wdata,
	output job_word_t rdata
);

	localparam int WORDS = NUM_CLASSES * QUEUE_DEPTH;

	job_word_t mem_q [WORDS];
	job_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/mqs_sched_ctrl.sv]
// ----------------------------------------------------------------------------
// mqs_sched_ctrl
// Sequencer: queue bookkeeping, class pick, cyclic slot scan, time update.
// ----------------------------------------------------------------------------
module mqs_sched_ctrl
	import mqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int AW = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	input  logic [SLICE_W-1:0] time_slice,
	output logic               res_valid,
	output result_t            res,
	input  logic               res_taken,
	output logic               mem_we,
	output logic               mem_re,
	output logic [AW-1:0]      mem_addr,
	output job_word_t          mem_wdata,
	input  job_word_t          mem_rdata
);

	localparam int EW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]                             count_q [NUM_CLASSES];
	logic [EW-1:0]                             cur_q   [NUM_CLASSES];
	logic [SLICE_W-1:0]                        slice_q [NUM_RR];
	logic [NUM_CLASSES-1:0][QUEUE_DEPTH-1:0]   pend_q;

	item_t          item_q;
	logic [CLS_W-1:0] c_q;
	logic [EW-1:0]  e_q;
	logic [EW-1:0]  p_q;
	logic           adv_q;
	result_t        res_q;
	result_t        res_dec;

	// class pick
	logic [NUM_CLASSES-1:0] busy;
	logic             any_busy;
	logic [CLS_W-1:0] c_sel;
	logic             sel_rr;
	logic [CW-1:0]    sel_cnt;
	logic [EW-1:0]    sel_cur;
	logic [SLICE_W-1:0] limit;
	logic             reselect;
	logic [EW-1:0]    from_e;
	logic [EW:0]      from_inc;
	logic [EW-1:0]    p_init;

	// scan
	logic [CW-1:0]    scan_cnt;
	logic [EW:0]      p_inc;
	logic [EW-1:0]    p_next;
	logic             hit;

	// add
	logic             add_ok;
	logic [CW-1:0]    add_cnt;

	// write back
	logic [7:0]       new_rem;

	always_comb begin
		busy     = '0;
		c_sel    = '0;
		any_busy = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			busy[c] = |pend_q[c];
		end
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (busy[c]) begin
				c_sel = CLS_W'(c);
			end
		end
		any_busy = |busy;
	end

	assign sel_rr   = (c_sel < CLS_W'(NUM_RR));
	assign sel_cnt  = count_q[c_sel];
	assign sel_cur  = cur_q[c_sel];
	assign limit    = (time_slice == '0) ? SLICE_W'(1) : time_slice;
	assign reselect = ((CW'(sel_cur) >= sel_cnt) || !pend_q[c_sel][sel_cur] ||
		(slice_q[c_sel[RR_IW-1:0]] >= limit));
	assign from_e   = (CW'(sel_cur) >= sel_cnt) ? EW'(sel_cnt - CW'(1)) : sel_cur;
	assign from_inc = {1'b0, from_e} + (EW+1)'(1);
	assign p_init   = (from_inc == (EW+1)'(sel_cnt)) ? '0 : from_inc[EW-1:0];

	assign scan_cnt = count_q[c_q];
	assign p_inc    = {1'b0, p_q} + (EW+1)'(1);
	assign p_next   = (p_inc == (EW+1)'(scan_cnt)) ? '0 : p_inc[EW-1:0];
	assign hit      = pend_q[c_q][p_q];

	assign add_cnt  = count_q[item_q.queue_class];
	assign add_ok   = (item_q.queue_class < CLS_W'(NUM_CLASSES)) &&
		(add_cnt < CW'(QUEUE_DEPTH));

	assign new_rem  = mem_rdata.remaining - 8'd1;

	// result of an add or an idle tick
	always_comb begin
		res_dec          = '0;
		res_dec.accepted = (item_q.func == FUNC_ADD) && add_ok;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (item_q.func == FUNC_ADD || !any_busy) begin
					state_d = ST_DONE;
				end else if (sel_rr && !reselect) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (res_taken) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		res_valid  = (state_q == ST_DONE);
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = AW'(c_q) * AW'(QUEUE_DEPTH) + AW'(e_q);
		mem_wdata  = '{job_id: mem_rdata.job_id, remaining: new_rem};
		unique case (state_q)
			ST_DECIDE: begin
				mem_addr  = AW'(item_q.queue_class) * AW'(QUEUE_DEPTH) + AW'(add_cnt);
				mem_wdata = '{job_id: item_q.job_id, remaining: item_q.exec_time};
				mem_we    = (item_q.func == FUNC_ADD) && add_ok;
			end
			ST_READ:  mem_re = 1'b1;
			ST_WRITE: mem_we = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				count_q[c] <= '0;
				cur_q[c]   <= '0;
			end
			for (int r = 0; r < NUM_RR; r++) begin
				slice_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE && item_q.func == FUNC_ADD && add_ok) begin
				count_q[item_q.queue_class] <= add_cnt + CW'(1);
				pend_q[item_q.queue_class][add_cnt[EW-1:0]] <= (item_q.exec_time != 8'd0);
			end
			if (state_q == ST_WRITE) begin
				cur_q[c_q] <= e_q;
				pend_q[c_q][e_q] <= (new_rem != 8'd0);
				if (c_q < CLS_W'(NUM_RR)) begin
					slice_q[c_q[RR_IW-1:0]] <= adv_q ? SLICE_W'(1) :
						slice_q[c_q[RR_IW-1:0]] + SLICE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_q <= item;
				end
			end
			ST_DECIDE: begin
				c_q   <= c_sel;
				e_q   <= sel_cur;
				adv_q <= !sel_rr || reselect;
				p_q   <= sel_rr ? p_init : '0;
				res_q <= res_dec;
			end
			ST_SCAN: begin
				if (hit) begin
					e_q <= p_q;
				end else begin
					p_q <= p_next;
				end
			end
			ST_WRITE: begin
				res_q <= '{accepted: 1'b0, ran_valid: 1'b1, ran_id: mem_rdata.job_id,
					ran_class: c_q, job_done: (new_rem == 8'd0)};
			end
			default: ;
		endcase
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel queue scheduler core. A behavioral
// scheduler mirrors the job table, turn pointers and slice counters and
// predicts every add and tick result. Directed cases open the run, then
// random phases with different time slices follow, with random idling on both
// sides of the block.
// ----------------------------------------------------------------------------
module tb
	import mqs_pkg::*;
();

	localparam int QD            = QUEUE_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 30;      // idle stretch after each drain
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int IDLE_PCT      = 13;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Mirror of the scheduler state.
	logic [15:0]        job_tag   [NUM_CLASSES][QD];
	logic [7:0]         work_left [NUM_CLASSES][QD];
	int                 fill      [NUM_CLASSES];
	int                 turn      [NUM_CLASSES];
	int                 slice_run [NUM_RR];
	logic [SLICE_W-1:0] slice_cfg;

	result_t due_results[$];
	result_t want;

	bit calm;
	int errors;
	int cycles;
	int n_items;
	int n_added;
	int n_ran;
	int n_settings;

	multilevel_queue_scheduler_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			due_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stall at random, except in calm stretches.
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Compare every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result transfer: %h", result);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (result.accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
					errors++;
				end
				if (result.ran_valid !== want.ran_valid) begin
					$error("ran_valid: expected %0d, got %0d", want.ran_valid, result.ran_valid);
					errors++;
				end
				if (result.ran_id !== want.ran_id) begin
					$error("ran_id: expected %0h, got %0h", want.ran_id, result.ran_id);
					errors++;
				end
				if (result.ran_class !== want.ran_class) begin
					$error("ran_class: expected %0d, got %0d", want.ran_class, result.ran_class);
					errors++;
				end
				if (result.job_done !== want.job_done) begin
					$error("job_done: expected %0d, got %0d", want.job_done, result.job_done);
					errors++;
				end
			end
		end
	end

	// Predict one item and advance the mirrored state.
	function automatic result_t schedule_item(input item_t it);
		result_t r;
		int      cls;
		int      e;
		int      k;
		int      n;
		int      from;
		int      lim;
		bit      hit;
		r = '0;
		cls = -1;
		if (func_t'(it.func) == FUNC_ADD) begin
			// Reject a bad class or a full queue; leave the state alone.
			if (it.queue_class < NUM_CLASSES && fill[it.queue_class] < QD) begin
				job_tag[it.queue_class][fill[it.queue_class]] = it.job_id;
				work_left[it.queue_class][fill[it.queue_class]] = it.exec_time;
				fill[it.queue_class]++;
				r.accepted = 1'b1;
				n_added++;
			end
			return r;
		end
		// Pick the highest-priority class with unfinished work.
		for (k = 0; k < NUM_CLASSES && cls < 0; k++)
			for (e = 0; e < fill[k]; e++)
				if (work_left[k][e] != 0)
					cls = k;
		if (cls < 0)
			return r;
		if (cls < NUM_RR) begin
			// A zero slice acts as one; a used-up slice passes the turn on.
			lim = (slice_cfg == 0) ? 1 : int'(slice_cfg);
			e = turn[cls];
			if (e >= fill[cls] || work_left[cls][e] == 0 || slice_run[cls] >= lim) begin
				n = fill[cls];
				from = (e >= n) ? n - 1 : e;
				e = from % n;
				hit = 1'b0;
				for (k = 1; k <= n; k++) begin
					if (!hit && work_left[cls][(from + k) % n] != 0) begin
						e = (from + k) % n;
						hit = 1'b1;
					end
				end
				slice_run[cls] = 0;
			end
			slice_run[cls]++;
		end else begin
			// First come first served: lowest unfinished slot.
			hit = 1'b0;
			e = 0;
			for (k = 0; k < fill[cls]; k++) begin
				if (!hit && work_left[cls][k] != 0) begin
					e = k;
					hit = 1'b1;
				end
			end
		end
		turn[cls] = e;
		work_left[cls][e]--;
		r.ran_valid = 1'b1;
		r.ran_id = job_tag[cls][e];
		r.ran_class = cls[CLS_W-1:0];
		r.job_done = (work_left[cls][e] == 0);
		n_ran++;
		return r;
	endfunction

	function automatic item_t make_add(input int cls, input logic [15:0] id,
		input logic [7:0] run_time);
		item_t it;
		it.func = FUNC_ADD;
		it.queue_class = cls[2:0];
		it.job_id = id;
		it.exec_time = run_time;
		return it;
	endfunction

	// Tick with noise in the fields the tick does not use.
	function automatic item_t make_tick();
		item_t it;
		it = item_t'($urandom);
		it.func = FUNC_TICK;
		return it;
	endfunction

	// Mostly ticks; adds carry mostly short jobs, a few bad classes and long runs.
	function automatic item_t random_item();
		int   p;
		int   cls;
		logic [7:0] run_time;
		if ($urandom_range(99) >= 12)
			return make_tick();
		cls = ($urandom_range(99) < 92) ? $urandom_range(NUM_CLASSES - 1) : $urandom_range(7, 5);
		p = $urandom_range(99);
		if (p < 70)
			run_time = 8'($urandom_range(8, 1));
		else if (p < 90)
			run_time = 8'($urandom_range(31));
		else
			run_time = 8'($urandom_range(255));
		return make_add(cls, 16'($urandom_range(16'hFFFF)), run_time);
	endfunction

	// Transfer one item, idling beforehand at random, then record the prediction.
	task automatic send_item(input item_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		due_results.push_back(schedule_item(it));
		n_items++;
	endtask

	// Drop valid and hold until every predicted result has been seen.
	task automatic wait_for_results();
		int guard;
		item_valid <= 1'b0;
		guard = 0;
		while (due_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			errors++;
			due_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_TIME_SLICE)
			slice_cfg = value[SLICE_W-1:0];
		@(posedge clk);
	endtask

	task automatic check_slice_reg();
		logic [APB_DW-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_TIME_SLICE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== {{(APB_DW - SLICE_W){1'b0}}, slice_cfg}) begin
			$error("time_slice readback: expected %0d, got %0h", slice_cfg, got);
			errors++;
		end
		@(posedge clk);
	endtask

	// Program the slice and read it back; only call with the block idle.
	task automatic set_slice(input logic [SLICE_W-1:0] value);
		write_reg(REG_TIME_SLICE, {16'($urandom_range(16'hFFFF)), 12'h000, value});
		check_slice_reg();
		n_settings++;
	endtask

	// Reset value, and a write to the unused index leaves the slice alone.
	task automatic test_register_map();
		check_slice_reg();
		write_reg(REG_UNUSED, $urandom);
		check_slice_reg();
	endtask

	task automatic test_idle_tick();
		send_item(make_tick());
		wait_for_results();
	endtask

	task automatic test_bad_class();
		send_item(make_add(5, 16'hFFFF, 8'hFF));
		send_item(make_add(7, 16'h0000, 8'h01));
		wait_for_results();
	endtask

	// Zero run time job is skipped; the other two share the turn.
	task automatic test_round_robin_turn();
		send_item(make_add(2, 16'hFFFF, 8'd0));
		send_item(make_add(2, 16'h0000, 8'd4));
		send_item(make_add(2, 16'hA5A5, 8'd2));
		repeat (6) send_item(make_tick());
		wait_for_results();
	endtask

	// Fill one first-come queue, then one add too many.
	task automatic test_full_queue();
		int k;
		for (k = 0; k <= QD; k++)
			send_item(make_add(3, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(3, 1))));
		wait_for_results();
	endtask

	// Run into a long slice, then lower the slice below what was used.
	task automatic test_slice_lowered();
		set_slice(4'd15);
		send_item(make_add(0, 16'($urandom_range(16'hFFFF)), 8'd10));
		repeat (4) send_item(make_tick());
		wait_for_results();
		set_slice(4'd2);
		repeat (2) send_item(make_tick());
		wait_for_results();
	endtask

	// Random traffic under one slice setting, with an optional calm stretch
	// and an optional mid-phase hold until all results are back.
	task automatic test_random_phase(input logic [SLICE_W-1:0] slice_val, input int count,
		input int calm_len, input int pause_at);
		int k;
		set_slice(slice_val);
		for (k = 0; k < count; k++) begin
			calm <= (k < calm_len);
			if (pause_at != 0 && k == pause_at)
				wait_for_results();
			send_item(random_item());
		end
		calm <= 1'b0;
		wait_for_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm <= 1'b0;
		cycles <= 0;
		errors = 0;
		n_items = 0;
		n_added = 0;
		n_ran = 0;
		n_settings = 0;
		slice_cfg = RESET_SLICE;
		foreach (fill[c]) begin
			fill[c] = 0;
			turn[c] = 0;
		end
		foreach (slice_run[c])
			slice_run[c] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_map();
		test_idle_tick();
		test_bad_class();
		test_round_robin_turn();
		test_full_queue();
		test_slice_lowered();
		test_random_phase(4'd1, 500, 0, 250);
		test_random_phase(4'd15, 500, 300, 0);
		test_random_phase(4'd0, 500, 0, 0);
		test_random_phase(SLICE_W'($urandom_range(14, 2)), 500, 0, 0);

		$display("Ran %0d items over %0d slice settings: %0d jobs stored, %0d job ticks run.",
			n_items, n_settings, n_added, n_ran);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[multilevel_queue_scheduler_core.f]
hw/rtl/mqs_pkg.sv
hw/rtl/mqs_job_mem.sv
hw/rtl/mqs_sched_ctrl.sv
hw/rtl/multilevel_queue_scheduler_core.sv
test/tb.sv
